### src/ssesc_pkg.sv
// shared constants, types and byte classes of the shell string escaper
`timescale 1ns / 1ps

package ssesc_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] CH_DOT    = 8'h2E;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_UNDER  = 8'h5F;
  localparam logic [ByteW-1:0] CH_BTICK  = 8'h60;

  // quoting state carried from one byte to the next
  typedef struct packed {
    logic single_quoted;
    logic double_quoted;
    logic escape_next;
    logic dq_backslash_pending;
  } ssesc_flags_t;

  // one classified byte handed to the output stage
  typedef struct packed {
    logic             need_bs;
    logic [ByteW-1:0] data;
  } ssesc_item_t;

  // bytes that need no backslash outside quotes
  function automatic logic is_safe(input logic [ByteW-1:0] b);
    logic r;
    r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
        (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER || b == CH_SLASH ||
        b == CH_SPACE || b == CH_TAB || b == CH_DOT || b == CH_COMMA;
    return r;
  endfunction

  // bytes that a backslash protects inside double quotes
  function automatic logic is_dq_special(input logic [ByteW-1:0] b);
    logic r;
    r = b == CH_DOLLAR || b == CH_BTICK || b == CH_LF ||
        b == CH_DQUOTE || b == CH_BSLASH;
    return r;
  endfunction

endpackage

### src/ssesc_decode.sv
// quoting state register and per-byte escape decision
`timescale 1ns / 1ps

module ssesc_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [ssesc_pkg::ByteW-1:0]  byte_in,
  output ssesc_pkg::ssesc_item_t       item
);

  ssesc_pkg::ssesc_flags_t flags_r;
  ssesc_pkg::ssesc_flags_t flags_nxt;
  logic                    need_bs;

  always_comb begin
    flags_nxt = flags_r;
    need_bs   = 1'b0;
    priority if (byte_in == ssesc_pkg::CH_NUL) begin
      flags_nxt = '0;
    end else if (byte_in[ssesc_pkg::ByteW-1]) begin
      flags_nxt.escape_next          = 1'b0;
      flags_nxt.dq_backslash_pending = 1'b0;
    end else if (flags_r.escape_next) begin
      flags_nxt.escape_next = 1'b0;
    end else if (flags_r.dq_backslash_pending && ssesc_pkg::is_dq_special(byte_in)) begin
      flags_nxt.dq_backslash_pending = 1'b0;
    end else begin
      flags_nxt.dq_backslash_pending = 1'b0;
      priority if (flags_r.single_quoted) begin
        if (byte_in == ssesc_pkg::CH_SQUOTE) flags_nxt.single_quoted = 1'b0;
      end else if (flags_r.double_quoted) begin
        priority if (byte_in == ssesc_pkg::CH_BSLASH) begin
          flags_nxt.dq_backslash_pending = 1'b1;
        end else if (byte_in == ssesc_pkg::CH_DQUOTE) begin
          flags_nxt.double_quoted = 1'b0;
        end else begin
          need_bs = ssesc_pkg::is_dq_special(byte_in);
        end
      end else begin
        priority if (byte_in == ssesc_pkg::CH_BSLASH) begin
          flags_nxt.escape_next = 1'b1;
        end else if (byte_in == ssesc_pkg::CH_SQUOTE) begin
          flags_nxt.single_quoted = 1'b1;
        end else if (byte_in == ssesc_pkg::CH_DQUOTE) begin
          flags_nxt.double_quoted = 1'b1;
        end else begin
          need_bs = !ssesc_pkg::is_safe(byte_in);
        end
      end
    end
  end

  assign item.need_bs = need_bs;
  assign item.data    = byte_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (take) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

### src/ssesc_out_stage.sv
// result register that splits an escaped byte into backslash and byte beats
`timescale 1ns / 1ps

module ssesc_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  ssesc_pkg::ssesc_item_t       item,
  output logic                         load,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ssesc_pkg::ByteW-1:0]  out_tdata,
  output logic                         out_tlast
);

  logic                        valid_r;
  logic                        bs_r;
  logic [ssesc_pkg::ByteW-1:0] data_r;

  // free once empty or once the final beat of the held item leaves
  assign load = item_valid && (!valid_r || (out_tready && !bs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      bs_r    <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      bs_r    <= item.need_bs;
    end else if (valid_r && out_tready) begin
      if (bs_r) begin
        bs_r <= 1'b0;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= item.data;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = bs_r ? ssesc_pkg::CH_BSLASH : data_r;
  assign out_tlast  = !bs_r;

endmodule

### src/shell_string_escaper.sv
// top level of the shell string escaper
`timescale 1ns / 1ps

// Shell string escaper: takes a string one byte per input beat and returns
// its shell-escaped form on the output stream.
// - in_tdata carries one source byte; a zero byte ends the string, is passed
//   on and returns the quoting state to unquoted
// - each input byte gives one output beat, or two when a backslash goes in
//   front of it; out_tlast marks the final beat belonging to that byte
// - a byte accepted into the input register is classified there against the
//   quoting state and moves into the output register once that register is
//   free, which advances the quoting state; its first beat is then offered
// - throughput: one byte per cycle while out_tready is high; a byte that
//   needs a backslash holds the output register over its pair of beats
// - in_tready stays high while the output register can take the next byte
//   or the input register is empty; with both full it needs out_tready
// - when the receiver holds out_tready low the output beat holds, then the
//   input register fills and in_tready drops; nothing is lost or repeated
// - reset (rst_n low, synchronous) empties both registers and clears the
//   quoting flags

module shell_string_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // last_of_run
);

  // input register
  logic                        in_valid_r;
  logic [ssesc_pkg::ByteW-1:0] in_byte_r;
  logic                        load;
  ssesc_pkg::ssesc_item_t      item;

  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  // quoting state advances when the byte moves into the output register
  ssesc_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (load),
    .byte_in (in_byte_r),
    .item    (item)
  );

  ssesc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### src/ssesc_checker.sv
// port-level checks of the shell string escaper
`timescale 1ns / 1ps

module ssesc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a beat that is not last is always the inserted backslash
  a_bs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata == ssesc_pkg::CH_BSLASH)
    else $error("non-last beat is not a backslash");

  // the escaped byte follows its backslash at once
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("escaped byte did not follow its backslash");

  // input backpressure only while output holds a beat
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind shell_string_escaper ssesc_checker u_ssesc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/shell_string_escaper_tb.sv
// self-checking stream testbench for the shell string escaper
`timescale 1ns / 1ps

module shell_string_escaper_tb;

  localparam int unsigned RandomBytes = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 27;

  // one expected output beat
  typedef struct packed {
    logic [ssesc_pkg::ByteW-1:0] data;
    logic                        last;
  } esc_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [ssesc_pkg::ByteW-1:0] in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [ssesc_pkg::ByteW-1:0] out_tdata;
  logic                        out_tlast;

  logic [ssesc_pkg::ByteW-1:0] source_bytes[$];  // bytes still to be sent
  esc_beat_t                   escaped_beats[$]; // beats the block still owes
  ssesc_pkg::ssesc_flags_t     quote_flags;      // predicted quoting state

  int unsigned cycle_cnt = 0;
  int unsigned n_fed = 0;
  int unsigned n_beats = 0;
  int unsigned n_inserted = 0;
  int unsigned n_strings = 0;
  int unsigned n_errors = 0;
  logic        calm;

  shell_string_escaper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tlast  (out_tlast)   // last_of_run
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // no random idling on either side for a stretch in the middle of the run
  assign calm = (n_fed >= 250) && (n_fed < 400);

  // digits, letters and a few punctuation bytes pass bare outside quotes
  function automatic logic plain_byte(input logic [ssesc_pkg::ByteW-1:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == ssesc_pkg::CH_UNDER ||
           b == ssesc_pkg::CH_SLASH || b == ssesc_pkg::CH_SPACE ||
           b == ssesc_pkg::CH_TAB || b == ssesc_pkg::CH_DOT ||
           b == ssesc_pkg::CH_COMMA;
  endfunction

  // bytes the shell still expands inside double quotes
  function automatic logic dq_live_byte(input logic [ssesc_pkg::ByteW-1:0] b);
    return b == ssesc_pkg::CH_DOLLAR || b == ssesc_pkg::CH_BTICK ||
           b == ssesc_pkg::CH_LF || b == ssesc_pkg::CH_DQUOTE ||
           b == ssesc_pkg::CH_BSLASH;
  endfunction

  function automatic void push_escaped(input logic [ssesc_pkg::ByteW-1:0] b,
                                       input logic with_bs);
    if (with_bs) begin
      escaped_beats.push_back(esc_beat_t'{data: ssesc_pkg::CH_BSLASH, last: 1'b0});
      n_inserted++;
    end
    escaped_beats.push_back(esc_beat_t'{data: b, last: 1'b1});
  endfunction

  // advances the quoting state by one source byte and queues its beats
  function automatic void escape_byte(input logic [ssesc_pkg::ByteW-1:0] b);
    logic guarded;
    guarded = 1'b0;
    if (b == ssesc_pkg::CH_NUL) begin
      // end of string: back to unquoted whatever the mode
      quote_flags = '0;
      n_strings++;
      push_escaped(b, 1'b0);
    end else if (b[7]) begin
      // high bytes pass bare and drop any pending protection
      quote_flags.escape_next = 1'b0;
      quote_flags.dq_backslash_pending = 1'b0;
      push_escaped(b, 1'b0);
    end else if (quote_flags.escape_next) begin
      quote_flags.escape_next = 1'b0;
      push_escaped(b, 1'b0);
    end else begin
      if (quote_flags.dq_backslash_pending) begin
        quote_flags.dq_backslash_pending = 1'b0;
        guarded = dq_live_byte(b);
      end
      if (guarded) begin
        push_escaped(b, 1'b0);
      end else if (quote_flags.single_quoted) begin
        if (b == ssesc_pkg::CH_SQUOTE) quote_flags.single_quoted = 1'b0;
        push_escaped(b, 1'b0);
      end else if (quote_flags.double_quoted) begin
        if (b == ssesc_pkg::CH_BSLASH) begin
          quote_flags.dq_backslash_pending = 1'b1;
          push_escaped(b, 1'b0);
        end else if (b == ssesc_pkg::CH_DQUOTE) begin
          quote_flags.double_quoted = 1'b0;
          push_escaped(b, 1'b0);
        end else begin
          push_escaped(b, dq_live_byte(b));
        end
      end else if (b == ssesc_pkg::CH_BSLASH) begin
        quote_flags.escape_next = 1'b1;
        push_escaped(b, 1'b0);
      end else if (b == ssesc_pkg::CH_SQUOTE) begin
        quote_flags.single_quoted = 1'b1;
        push_escaped(b, 1'b0);
      end else if (b == ssesc_pkg::CH_DQUOTE) begin
        quote_flags.double_quoted = 1'b1;
        push_escaped(b, 1'b0);
      end else begin
        push_escaped(b, !plain_byte(b));
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] error: %s", $realtime, what);
  endtask

  // mostly quoting-heavy text with random content, some raw noise
  function automatic logic [ssesc_pkg::ByteW-1:0] text_byte();
    logic [ssesc_pkg::ByteW-1:0] hot[10];
    int unsigned                 r;
    hot = '{ssesc_pkg::CH_DQUOTE, ssesc_pkg::CH_SQUOTE, ssesc_pkg::CH_BSLASH,
            ssesc_pkg::CH_BSLASH, ssesc_pkg::CH_DOLLAR, ssesc_pkg::CH_BTICK,
            ssesc_pkg::CH_LF, ssesc_pkg::CH_TAB, "!", "a"};
    r = $urandom_range(99);
    if (r < 45) return hot[$urandom_range(9)];
    if (r < 70) return 8'(" " + $urandom_range(94));
    if (r < 80) return 8'($urandom_range(8'h80, 8'hFF));
    if (r < 95) return 8'($urandom_range(255));
    return ssesc_pkg::CH_NUL;
  endfunction

  // sender: holds a beat until taken, gaps at random outside the calm stretch
  always @(posedge clk) begin
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (source_bytes.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= source_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // every accepted byte updates the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      escape_byte(in_tdata);
      n_fed++;
    end
  end

  // every accepted result beat is checked against the oldest prediction
  always @(posedge clk) begin
    esc_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (escaped_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%02h last=%b",
                                  out_tdata, out_tlast));
      end else begin
        want = escaped_beats.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last)
          report_mismatch($sformatf("beat %0d: data=%02h last=%b, want data=%02h last=%b",
                                    n_beats, out_tdata, out_tlast, want.data, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still owed",
               cycle_cnt, escaped_beats.size());
      $display("shell_string_escaper: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (source_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (escaped_beats.size() != 0) @(posedge clk);
  endtask

  initial begin
    quote_flags = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, unquoted escaping, each quoting mode,
    // protected bytes after a backslash in double quotes, high bytes
    // clearing protection, end of string inside an open quote
    source_bytes = '{
      "a", "!", 8'h7F, 8'h80, 8'hFF, ssesc_pkg::CH_TAB, 8'h01,
      // escaped quote stays unquoted
      ssesc_pkg::CH_BSLASH, ssesc_pkg::CH_SQUOTE,
      // single-quoted run
      ssesc_pkg::CH_SQUOTE, ssesc_pkg::CH_DOLLAR, ssesc_pkg::CH_BSLASH,
      ssesc_pkg::CH_SQUOTE,
      ssesc_pkg::CH_DQUOTE, ssesc_pkg::CH_DOLLAR, ssesc_pkg::CH_BTICK,
      ssesc_pkg::CH_LF, "a",
      ssesc_pkg::CH_BSLASH, ssesc_pkg::CH_DOLLAR, ssesc_pkg::CH_BSLASH, "q",
      ssesc_pkg::CH_BSLASH, 8'hC3, ssesc_pkg::CH_DQUOTE,
      // high byte drops the escape
      ssesc_pkg::CH_BSLASH, 8'hA0, "~",
      // end of string inside quotes
      ssesc_pkg::CH_DQUOTE, ssesc_pkg::CH_NUL, "&"
    };
    drain();  // sender holds off until every result is back

    for (int unsigned i = 0; i < RandomBytes; i++) begin
      source_bytes.push_back(text_byte());
      if (i == RandomBytes / 2) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d strings, got %0d beats with %0d inserted backslashes",
             n_fed, n_strings, n_beats, n_inserted);
    $display("quoting modes, protected bytes, high bytes and stalls on both sides exercised");
    if (n_errors == 0 && escaped_beats.size() == 0) begin
      $display("shell_string_escaper: match");
    end else begin
      $display("shell_string_escaper: mismatch");
    end
    $finish;
  end

endmodule
